// File: src/trie_prefix_match_engine_macros.svh
// ----------------------------------------------------------------------------
// Trie prefix match engine assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIE_PREFIX_MATCH_ENGINE_MACROS_SVH
`define TRIE_PREFIX_MATCH_ENGINE_MACROS_SVH

// condition that must hold in the same cycle
`define TPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition a implies b in the next cycle
`define TPM_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// File: src/tpm_pkg.sv
// ----------------------------------------------------------------------------
// Trie prefix match engine package
// Sizes, state codes and the cell control struct.
// ----------------------------------------------------------------------------
package tpm_pkg;

  localparam int MAX_NODES   = 4096;
  localparam int MAX_LENGTH  = 10;
  localparam int NUM_SYMS    = 10;
  localparam int NCELL       = (MAX_LENGTH < NUM_SYMS) ? MAX_LENGTH : NUM_SYMS;
  localparam int TABLE_DEPTH = MAX_NODES * MAX_LENGTH;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int CNT_W       = NODE_W + 1;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int SYM_W       = 4;

  localparam logic [SYM_W-1:0] LEN_RESET = SYM_W'(10);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_QUERY  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_INV   = 6'b000100,
    ST_RD    = 6'b001000,
    ST_WAIT  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  typedef struct packed {
    logic load_pair;
    logic load_sym;
    logic rotate;
    logic shift;
  } cell_ctrl_t;

endpackage

// File: src/trie_prefix_match_engine.sv
// Insert inverts the sequence on the cell row (INV) and then walks the trie; query walks it
// directly; clear writes every child-table entry. A query stops early on a bad symbol or a
// missing child, an insert on a bad symbol or a full table. Each trie level is a
// child-table read (RD), then a link/decide step on the read data (WAIT). One item is in
// flight; the next is taken from the cycle after the result is loaded, and a result still
// waiting in the output register holds the item in DONE. Reset (rst_n low, synchronous)
// clears control state and clears all TABLE_DEPTH (40960) table entries, taking no transaction.
// ----------------------------------------------------------------------------
// Trie prefix match engine
// Trie of symbol sequences with inverted-permutation insert and
// longest-prefix query, walked one level at a time over a row of cells.
// ----------------------------------------------------------------------------
`include "trie_prefix_match_engine_macros.svh"

module trie_prefix_match_engine import tpm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [SYM_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_func,
  input  logic [SYM_W-1:0] in_sym_1,
  input  logic [SYM_W-1:0] in_sym_2,
  input  logic [SYM_W-1:0] in_sym_3,
  input  logic [SYM_W-1:0] in_sym_4,
  input  logic [SYM_W-1:0] in_sym_5,
  input  logic [SYM_W-1:0] in_sym_6,
  input  logic [SYM_W-1:0] in_sym_7,
  input  logic [SYM_W-1:0] in_sym_8,
  input  logic [SYM_W-1:0] in_sym_9,
  input  logic [SYM_W-1:0] in_sym_10,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SYM_W-1:0] out_match_length,
  output logic             out_table_full
);

  state_t            state_r, state_nxt;
  logic [SYM_W-1:0]  cfg_len_r, cfg_len_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              clr_item_r, clr_item_nxt;
  logic [CNT_W-1:0]  nodes_used_r, nodes_used_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]  out_match_r, out_match_nxt;
  logic              out_full_r, out_full_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [SYM_W-1:0]  walk_cnt_r, walk_cnt_nxt;
  logic [SYM_W-1:0]  rot_cnt_r, rot_cnt_nxt;
  logic              is_ins_r, is_ins_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [SYM_W-1:0]  res_match_r, res_match_nxt;
  logic              res_full_r, res_full_nxt;

  logic [SYM_W-1:0]  len_eff;
  logic [SYM_W-1:0]  in_sym [NUM_SYMS];
  logic [SYM_W-1:0]  cell_pos [NCELL];
  logic [SYM_W-1:0]  cell_val [NCELL];
  logic [SYM_W-1:0]  cell_sym [NCELL];
  cell_ctrl_t        cell_ctrl;
  logic [SYM_W-1:0]  sym0;
  logic              sym_bad;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  next_id;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [NODE_W-1:0] ram_wdata;
  logic [NODE_W-1:0] ram_rdata;
  logic              accept;

  assign in_sym[0] = in_sym_1;
  assign in_sym[1] = in_sym_2;
  assign in_sym[2] = in_sym_3;
  assign in_sym[3] = in_sym_4;
  assign in_sym[4] = in_sym_5;
  assign in_sym[5] = in_sym_6;
  assign in_sym[6] = in_sym_7;
  assign in_sym[7] = in_sym_8;
  assign in_sym[8] = in_sym_9;
  assign in_sym[9] = in_sym_10;

  assign len_eff = (cfg_len_r > SYM_W'(NCELL)) ? SYM_W'(NCELL) : cfg_len_r;

  // row of cells: pairs rotate as a ring, walk symbols shift toward cell 0
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    logic [SYM_W-1:0] sym_in;
    if (k == NCELL - 1) begin : g_last
      assign sym_in = '0;
    end else begin : g_mid
      assign sym_in = cell_sym[k+1];
    end
    tpm_cell u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .idx     (SYM_W'(k + 1)),
      .len     (len_eff),
      .ld_val  (in_sym[k]),
      .pos_in  (cell_pos[(k+1) % NCELL]),
      .val_in  (cell_val[(k+1) % NCELL]),
      .sym_in  (sym_in),
      .pos_out (cell_pos[k]),
      .val_out (cell_val[k]),
      .sym_out (cell_sym[k])
    );
  end

  tpm_ram #(
    .WIDTH (NODE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_child_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign sym0     = cell_sym[0];
  assign sym_bad  = (sym0 == '0) || (sym0 > len_eff);
  assign rd_addr  = ADDR_W'(node_r) * ADDR_W'(MAX_LENGTH) + ADDR_W'(sym0) - ADDR_W'(1);
  assign next_id  = nodes_used_r + CNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    cfg_len_nxt    = cfg_wr_en ? cfg_wr_data : cfg_len_r;
    clr_addr_nxt   = clr_addr_r;
    clr_item_nxt   = clr_item_r;
    nodes_used_nxt = nodes_used_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_match_nxt  = out_match_r;
    out_full_nxt   = out_full_r;
    node_nxt       = node_r;
    walk_cnt_nxt   = walk_cnt_r;
    rot_cnt_nxt    = rot_cnt_r;
    is_ins_nxt     = is_ins_r;
    addr_nxt       = addr_r;
    res_match_nxt  = res_match_r;
    res_full_nxt   = res_full_r;
    cell_ctrl      = '0;
    ram_we         = 1'b0;
    ram_addr       = rd_addr;
    ram_wdata      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          node_nxt      = '0;
          walk_cnt_nxt  = '0;
          rot_cnt_nxt   = '0;
          res_match_nxt = '0;
          res_full_nxt  = 1'b0;
          is_ins_nxt    = (in_func == FUNC_INSERT);
          case (in_func)
            FUNC_INSERT: begin
              cell_ctrl.load_pair = 1'b1;
              state_nxt           = ST_INV;
            end
            FUNC_QUERY: begin
              cell_ctrl.load_sym = 1'b1;
              state_nxt          = ST_RD;
            end
            FUNC_CLEAR: begin
              clr_addr_nxt = '0;
              clr_item_nxt = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_addr     = clr_addr_r;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(TABLE_DEPTH - 1)) begin
          nodes_used_nxt = '0;
          clr_item_nxt   = 1'b0;
          state_nxt      = clr_item_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_INV: begin
        cell_ctrl.rotate = 1'b1;
        rot_cnt_nxt      = rot_cnt_r + SYM_W'(1);
        if (rot_cnt_r == SYM_W'(NCELL - 1)) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        // stop on a full walk or a symbol outside the alphabet
        if ((walk_cnt_r == len_eff) || sym_bad) begin
          res_match_nxt = is_ins_r ? '0 : walk_cnt_r;
          state_nxt     = ST_DONE;
        end else begin
          addr_nxt  = rd_addr;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        ram_addr = addr_r;
        if (ram_rdata != '0) begin
          node_nxt        = ram_rdata;
          walk_cnt_nxt    = walk_cnt_r + SYM_W'(1);
          cell_ctrl.shift = 1'b1;
          state_nxt       = ST_RD;
        end else if (!is_ins_r) begin
          res_match_nxt = walk_cnt_r;
          state_nxt     = ST_DONE;
        end else if (next_id >= CNT_W'(MAX_NODES)) begin
          res_full_nxt = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          ram_we          = 1'b1;
          ram_wdata       = next_id[NODE_W-1:0];
          nodes_used_nxt  = next_id;
          node_nxt        = next_id[NODE_W-1:0];
          walk_cnt_nxt    = walk_cnt_r + SYM_W'(1);
          cell_ctrl.shift = 1'b1;
          state_nxt       = ST_RD;
        end
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_match_nxt = res_match_r;
          out_full_nxt  = res_full_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cfg_len_r    <= LEN_RESET;
      clr_addr_r   <= '0;
      clr_item_r   <= 1'b0;
      nodes_used_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cfg_len_r    <= cfg_len_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_item_r   <= clr_item_nxt;
      nodes_used_r <= nodes_used_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_match_r <= out_match_nxt;
    out_full_r  <= out_full_nxt;
    node_r      <= node_nxt;
    walk_cnt_r  <= walk_cnt_nxt;
    rot_cnt_r   <= rot_cnt_nxt;
    is_ins_r    <= is_ins_nxt;
    addr_r      <= addr_nxt;
    res_match_r <= res_match_nxt;
    res_full_r  <= res_full_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_match_length = out_match_r;
  assign out_table_full   = out_full_r;

  `TPM_ASSERT(a_no_write_when_ready, !(in_ready && ram_we), "child table written while idle")
  `TPM_ASSERT(a_nodes_bound, nodes_used_r < CNT_W'(MAX_NODES), "node counter out of range")
  `TPM_ASSERT_NEXT(a_link_allocates, (state_r == ST_WAIT) && ram_we, nodes_used_r == CNT_W'($past(nodes_used_r) + CNT_W'(1)), "link without node allocation")

endmodule

// File: src/tpm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module tpm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 40960
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: src/tpm_cell.sv
// ----------------------------------------------------------------------------
// Trie prefix match symbol cell
// Holds one rotating (position, value) pair and one walk symbol; inverts by
// capturing the latest position whose value equals its own index.
// ----------------------------------------------------------------------------
module tpm_cell import tpm_pkg::*; (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [SYM_W-1:0] idx,
  input  logic [SYM_W-1:0] len,
  input  logic [SYM_W-1:0] ld_val,
  input  logic [SYM_W-1:0] pos_in,
  input  logic [SYM_W-1:0] val_in,
  input  logic [SYM_W-1:0] sym_in,
  output logic [SYM_W-1:0] pos_out,
  output logic [SYM_W-1:0] val_out,
  output logic [SYM_W-1:0] sym_out
);

  logic [SYM_W-1:0] pos_r, pos_nxt;
  logic [SYM_W-1:0] val_r, val_nxt;
  logic [SYM_W-1:0] sym_r, sym_nxt;
  logic             hit;

  // later position wins on duplicate values
  assign hit = (pos_r != '0) && (val_r == idx) && (idx <= len) && (pos_r > sym_r);

  always_comb begin
    pos_nxt = pos_r;
    val_nxt = val_r;
    sym_nxt = sym_r;
    if (ctrl.load_pair) begin
      pos_nxt = (idx <= len) ? idx : '0;
      val_nxt = ld_val;
      sym_nxt = '0;
    end else if (ctrl.load_sym) begin
      sym_nxt = ld_val;
    end else if (ctrl.rotate) begin
      pos_nxt = pos_in;
      val_nxt = val_in;
      if (hit) begin
        sym_nxt = pos_r;
      end
    end else if (ctrl.shift) begin
      sym_nxt = sym_in;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    sym_r <= sym_nxt;
  end

  assign pos_out = pos_r;
  assign val_out = val_r;
  assign sym_out = sym_r;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie prefix match engine testbench
// Random and directed inserts, queries and clears against a behavioral trie,
// under random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import tpm_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]             func;
    logic [10:1][SYM_W-1:0] sym;
  } trie_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] match_length;
    logic             table_full;
  } trie_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [SYM_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_func = '0;
  logic [10:1][SYM_W-1:0] in_sym = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SYM_W-1:0] out_match_length;
  logic out_table_full;

  trie_prefix_match_engine i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_sym_1         (in_sym[1]),
    .in_sym_2         (in_sym[2]),
    .in_sym_3         (in_sym[3]),
    .in_sym_4         (in_sym[4]),
    .in_sym_5         (in_sym[5]),
    .in_sym_6         (in_sym[6]),
    .in_sym_7         (in_sym[7]),
    .in_sym_8         (in_sym[8]),
    .in_sym_9         (in_sym[9]),
    .in_sym_10        (in_sym[10]),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_match_length (out_match_length),
    .out_table_full   (out_table_full)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // behavioral trie
  int unsigned trie_child [TABLE_DEPTH];
  int unsigned trie_nodes_used;
  logic [SYM_W-1:0] seq_len_reg = LEN_RESET;

  trie_item_t   pending_items [$];
  trie_result_t expected_results [$];
  logic [10:1][SYM_W-1:0] inserted_perms [$];
  int unsigned fail_count = 0;
  bit idle_en = 1'b1;

  function automatic int unsigned active_len();
    return (seq_len_reg > NCELL) ? NCELL : seq_len_reg;
  endfunction

  function automatic void trie_clear();
    for (int i = 0; i < TABLE_DEPTH; i++) trie_child[i] = 0;
    trie_nodes_used = 0;
  endfunction

  function automatic trie_result_t trie_apply(trie_item_t it);
    trie_result_t res;
    int unsigned len;
    int unsigned inv [1:10];
    int unsigned node;
    int unsigned s;
    int unsigned idx;
    bit stop;
    res = '0;
    len = active_len();
    node = 0;
    stop = 1'b0;
    case (it.func)
      FUNC_INSERT: begin
        for (int i = 1; i <= 10; i++) inv[i] = 0;
        for (int i = 1; i <= len; i++)
          if (it.sym[i] >= 1 && it.sym[i] <= len) inv[it.sym[i]] = i;
        for (int i = 1; i <= len && !stop; i++) begin
          s = inv[i];
          if (s < 1 || s > len) begin
            stop = 1'b1;
          end else begin
            idx = node * MAX_LENGTH + s - 1;
            if (trie_child[idx] == 0) begin
              if (trie_nodes_used + 1 >= MAX_NODES) begin
                res.table_full = 1'b1;
                stop = 1'b1;
              end else begin
                trie_nodes_used++;
                trie_child[idx] = trie_nodes_used;
              end
            end
            if (!stop) node = trie_child[idx];
          end
        end
      end
      FUNC_QUERY: begin
        for (int i = 1; i <= len && !stop; i++) begin
          s = it.sym[i];
          if (s < 1 || s > len || trie_child[node * MAX_LENGTH + s - 1] == 0) begin
            stop = 1'b1;
          end else begin
            node = trie_child[node * MAX_LENGTH + s - 1];
            res.match_length++;
          end
        end
      end
      FUNC_CLEAR: trie_clear();
      default: ;
    endcase
    return res;
  endfunction

  // stimulus builders
  function automatic logic [10:1][SYM_W-1:0] rand_perm(int unsigned len);
    logic [10:1][SYM_W-1:0] p;
    int unsigned j;
    logic [SYM_W-1:0] t;
    p = '0;
    for (int i = 1; i <= len; i++) p[i] = SYM_W'(i);
    for (int i = len; i > 1; i--) begin
      j = $urandom_range(1, i);
      t = p[i]; p[i] = p[j]; p[j] = t;
    end
    return p;
  endfunction

  function automatic logic [10:1][SYM_W-1:0] noise_syms();
    logic [10:1][SYM_W-1:0] p;
    for (int i = 1; i <= 10; i++) p[i] = SYM_W'($urandom_range(0, 15));
    return p;
  endfunction

  function automatic trie_item_t build_random(int unsigned len, int unsigned ins_pct);
    trie_item_t it;
    int unsigned r;
    logic [10:1][SYM_W-1:0] p;
    r = $urandom_range(0, 99);
    it.sym = '0;
    if (r < 2) begin
      it.func = FUNC_UNUSED;
      it.sym = noise_syms();
    end else if (r < ins_pct) begin
      it.func = FUNC_INSERT;
      if ($urandom_range(0, 4) == 0) begin
        it.sym = noise_syms();
      end else begin
        it.sym = rand_perm(len);
        inserted_perms.push_back(it.sym);
      end
    end else begin
      it.func = FUNC_QUERY;
      if (inserted_perms.size() > 0 && $urandom_range(0, 9) < 7) begin
        p = inserted_perms[$urandom_range(0, inserted_perms.size() - 1)];
        // query with the inverted sequence, so the walk follows a stored path
        for (int i = 1; i <= len; i++)
          if (p[i] >= 1 && p[i] <= len) it.sym[p[i]] = SYM_W'(i);
        if ($urandom_range(0, 2) == 0 && len > 0)
          it.sym[$urandom_range(1, len)] = SYM_W'($urandom_range(0, 15));
      end else begin
        it.sym = noise_syms();
      end
    end
    return it;
  endfunction

  task automatic push_item(logic [1:0] f, logic [10:1][SYM_W-1:0] s);
    trie_item_t it;
    it.func = f;
    it.sym = s;
    pending_items.push_back(it);
  endtask

  task automatic run_random(int unsigned count, int unsigned ins_pct);
    for (int i = 0; i < count; i++)
      pending_items.push_back(build_random(active_len(), ins_pct));
  endtask

  // sample on the falling edge, after every clocked update has settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_len(logic [SYM_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    seq_len_reg = v;
    inserted_perms.delete();
  endtask

  // driver
  trie_item_t cur_item;
  int unsigned in_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(trie_apply(cur_item));
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_func <= cur_item.func;
          in_sym <= cur_item.sym;
          in_valid <= 1'b1;
          in_gap = idle_en ? $urandom_range(0, 4) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int unsigned out_stall = 0;
  int unsigned hold_left = 0;
  int unsigned results_seen = 0;
  trie_result_t exp_res;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with no transaction pending: match_length %0d table_full %0d",
                 out_match_length, out_table_full);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_match_length !== exp_res.match_length) begin
            $error("match_length expected %0d actual %0d",
                   exp_res.match_length, out_match_length);
            fail_count++;
          end
          if (out_table_full !== exp_res.table_full) begin
            $error("table_full expected %0d actual %0d",
                   exp_res.table_full, out_table_full);
            fail_count++;
          end
        end
        out_stall = idle_en ? $urandom_range(0, 4) : 0;
        // hold off once for long enough that the input backs up
        if (results_seen == 300) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [10:1][SYM_W-1:0] idp;
    logic [10:1][SYM_W-1:0] tmp;
    trie_clear();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed, length 10 from reset
    for (int i = 1; i <= 10; i++) idp[i] = SYM_W'(i);
    push_item(FUNC_QUERY, idp);
    push_item(FUNC_INSERT, idp);
    push_item(FUNC_QUERY, idp);
    tmp = idp; tmp[10] = 4'd9;
    push_item(FUNC_QUERY, tmp);
    tmp = idp; tmp[5] = 4'd0;
    push_item(FUNC_INSERT, tmp);                 // hole after inversion
    tmp = idp; tmp[4] = 4'd3;
    push_item(FUNC_INSERT, tmp);                 // duplicate value
    tmp = idp; tmp[2] = 4'd15;
    push_item(FUNC_INSERT, tmp);                 // out-of-range value
    tmp = idp; tmp[3] = 4'd0;
    push_item(FUNC_QUERY, tmp);                  // bad query symbol
    tmp = idp; tmp[1] = 4'd11;
    push_item(FUNC_QUERY, tmp);
    push_item(FUNC_INSERT, '1);
    push_item(FUNC_QUERY, '1);
    push_item(FUNC_INSERT, '0);
    push_item(FUNC_QUERY, '0);
    for (int i = 1; i <= 10; i++) tmp[i] = SYM_W'(11 - i);
    push_item(FUNC_INSERT, tmp);
    push_item(FUNC_QUERY, tmp);
    push_item(FUNC_UNUSED, idp);
    push_item(FUNC_UNUSED, '1);
    push_item(FUNC_CLEAR, '0);
    push_item(FUNC_QUERY, idp);
    wait_idle();

    run_random(350, 50);
    wait_idle();

    write_len(4'd3);
    run_random(180, 40);
    wait_idle();

    write_len(4'd0);
    run_random(30, 50);
    wait_idle();

    // fill the node space until inserts report full
    write_len(4'd15);
    push_item(FUNC_CLEAR, '0);
    idle_en = 1'b0;
    run_random(150, 85);
    wait_idle();
    idle_en = 1'b1;
    run_random(500, 85);
    wait_idle();
    push_item(FUNC_CLEAR, '0);
    wait_idle();

    write_len(4'd1);
    run_random(100, 50);
    wait_idle();

    write_len(4'd5);
    run_random(200, 50);
    wait_idle();

    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: trie_prefix_match_engine.f
+incdir+src
src/tpm_pkg.sv
src/tpm_ram.sv
src/tpm_cell.sv
src/trie_prefix_match_engine.sv
test/tb.sv
